// ----- hw/rtl/kpv_pkg.sv -----
package kpv_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DATA_WIDTH = 32;

  // width that holds any 32-bit field and any sum of two data words
  localparam int EXT_W = (DATA_WIDTH > 32 ? DATA_WIDTH : 32) + 1;
  localparam int PW    = 2 * DATA_WIDTH;
  // dividend 2^(2F) + d/2 of the reciprocal
  localparam int NUM_W = ((2 * FRAC_BITS > DATA_WIDTH - 2) ? 2 * FRAC_BITS : DATA_WIDTH - 2) + 2;

  typedef logic signed [DATA_WIDTH-1:0] q_t;
  typedef logic signed [EXT_W-1:0]      ext_t;
  typedef logic signed [PW-1:0]         prod_t;
  typedef logic        [PW-1:0]         umag_t;

  localparam q_t   Q_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam q_t   Q_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam ext_t O_MAX = ext_t'(32'sh7FFFFFFF);
  localparam ext_t O_MIN = ext_t'(-32'sh7FFFFFFF - 32'sh1);

  typedef struct packed {
    logic signed [31:0] meas_position;
    logic signed [31:0] meas_velocity;
  } in_t;

  typedef struct packed {
    logic signed [31:0] est_position;
    logic signed [31:0] est_velocity;
    logic signed [31:0] position_gap;
  } out_t;

  typedef struct packed {
    q_t step_time;
    q_t meas_noise;
    q_t vel_offset;
    q_t proc_noise_pos;
    q_t proc_noise_vel;
    q_t init_var_pos;
    q_t init_var_vel;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_STEP_TIME      = 3'd0,
    REG_MEAS_NOISE     = 3'd1,
    REG_VEL_OFFSET     = 3'd2,
    REG_PROC_NOISE_POS = 3'd3,
    REG_PROC_NOISE_VEL = 3'd4,
    REG_INIT_VAR_POS   = 3'd5,
    REG_INIT_VAR_VEL   = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_SHR} alu_op_t;

  typedef struct packed {
    alu_op_t op;
    q_t      a;
    q_t      b;
  } alu_req_t;

  typedef enum logic [5:0] {
    S_IDLE, S_Z, S_D, S_DVS, S_DIV, S_K0, S_K1, S_INNOV,
    S_M1, S_X0, S_M2, S_X1, S_M3, S_C00, S_M4, S_C01, S_M5, S_C10, S_M6, S_C11,
    S_EMIT, S_TT, S_G0, S_TX1, S_E0A, S_E0, S_E1, S_TA, S_TB, S_U,
    S_S, S_GU, S_XP0, S_TU, S_XP1, S_TP10, S_P00A, S_TP11, S_P01,
    S_TP01, S_P00B, S_P00C, S_TP11B, S_P10, S_P11
  } state_t;

  typedef enum logic [4:0] {
    D_NONE, D_Z, D_DSUM, D_K0, D_K1, D_INNOV, D_M, D_X0, D_X1, D_OUT,
    D_G0, D_TX1, D_E0, D_E1, D_TA, D_U, D_ACC, D_XP0, D_XP1,
    D_P00, D_P01, D_P10, D_P11
  } dst_t;

  function automatic q_t sat_ext(ext_t v);
    if (v > ext_t'(Q_MAX)) return Q_MAX;
    else if (v < ext_t'(Q_MIN)) return Q_MIN;
    else return q_t'(v);
  endfunction

  function automatic q_t sat_s32(logic signed [31:0] x);
    return sat_ext(ext_t'(x));
  endfunction

  function automatic q_t sat_u31(logic [30:0] x);
    return sat_ext(ext_t'(x));
  endfunction

  function automatic logic signed [31:0] q_to_out(q_t v);
    ext_t w;
    w = ext_t'(v);
    if (w > O_MAX) return 32'sh7FFFFFFF;
    else if (w < O_MIN) return -32'sh7FFFFFFF - 32'sh1;
    else return w[31:0];
  endfunction

  function automatic q_t q_add(q_t a, q_t b);
    return sat_ext(ext_t'(a) + ext_t'(b));
  endfunction

  function automatic q_t q_sub(q_t a, q_t b);
    return sat_ext(ext_t'(a) - ext_t'(b));
  endfunction

  // exact product, round half away from zero, saturate
  function automatic q_t q_mul(q_t a, q_t b);
    prod_t p;
    umag_t mag;
    umag_t rnd;
    umag_t lim;
    logic  neg;
    p   = prod_t'(a) * prod_t'(b);
    neg = p[PW-1];
    mag = neg ? umag_t'(-p) : umag_t'(p);
    rnd = (mag + (umag_t'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    lim = neg ? umag_t'(Q_MAX) + umag_t'(1) : umag_t'(Q_MAX);
    if (rnd > lim) rnd = lim;
    mag = neg ? -rnd : rnd;
    return q_t'(mag);
  endfunction

endpackage

// ----- hw/rtl/kpv_alu.sv -----
module kpv_alu (
  input  kpv_pkg::alu_req_t req,
  output kpv_pkg::q_t       y
);
  import kpv_pkg::*;

  always_comb begin
    unique case (req.op)
      OP_ADD:  y = q_add(req.a, req.b);
      OP_SUB:  y = q_sub(req.a, req.b);
      OP_MUL:  y = q_mul(req.a, req.b);
      OP_SHR:  y = req.a >>> 1;
      default: y = '0;
    endcase
  end

endmodule

// ----- hw/rtl/kpv_div.sv -----
// reciprocal round(2^(2F)/d) for d > 0, one quotient bit per cycle
module kpv_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  kpv_pkg::q_t d,
  output logic        done,
  output kpv_pkg::q_t quo
);
  import kpv_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DATA_WIDTH-2:0] dv;
  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] trial;
  logic [NUM_W-1:0]      num;
  logic [CNT_W-1:0]      cnt;
  logic                  running;
  logic                  ge;

  assign trial = {rem[DATA_WIDTH-2:0], num[NUM_W-1]};
  assign ge    = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(NUM_W);
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dv  <= d[DATA_WIDTH-2:0];
      num <= (NUM_W'(1) << (2 * FRAC_BITS)) + NUM_W'(d[DATA_WIDTH-2:1]);
      rem <= '0;
    end else if (running) begin
      rem <= ge ? trial - {1'b0, dv} : trial;
      num <= {num[NUM_W-2:0], ge};
    end
  end

  assign quo = (|num[NUM_W-1:DATA_WIDTH-1]) ? Q_MAX : q_t'({1'b0, num[DATA_WIDTH-2:0]});

endmodule

// ----- hw/rtl/kpv_core.sv -----
module kpv_core (
  input  logic          clk,
  input  logic          rst,
  input  kpv_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  kpv_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output kpv_pkg::out_t out_data
);
  import kpv_pkg::*;

  state_t   state, state_next;
  logic     started;
  alu_req_t req;
  dst_t     dst;
  q_t       y;
  logic     div_start, div_done;
  q_t       div_quo;
  logic     out_free;

  q_t pos, vel, xp0, xp1, p00, p01, p10, p11;
  q_t z, dsum, inv, k0, k1, innov, m, x0, x1, g0, tx1, e0, e1, ta, u, acc;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  kpv_alu u_alu (.req(req), .y(y));

  kpv_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .d(dsum), .done(div_done), .quo(div_quo)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = started ? S_Z : S_IDLE;
      S_Z:     state_next = S_D;
      S_D:     state_next = S_DVS;
      S_DVS:   state_next = (dsum > q_t'(0)) ? S_DIV : S_K0;
      S_DIV:   if (div_done) state_next = S_K0;
      S_K0:    state_next = S_K1;
      S_K1:    state_next = S_INNOV;
      S_INNOV: state_next = S_M1;
      S_M1:    state_next = S_X0;
      S_X0:    state_next = S_M2;
      S_M2:    state_next = S_X1;
      S_X1:    state_next = S_M3;
      S_M3:    state_next = S_C00;
      S_C00:   state_next = S_M4;
      S_M4:    state_next = S_C01;
      S_C01:   state_next = S_M5;
      S_M5:    state_next = S_C10;
      S_C10:   state_next = S_M6;
      S_M6:    state_next = S_C11;
      S_C11:   state_next = S_EMIT;
      S_EMIT:  if (out_free) state_next = S_TT;
      S_TT:    state_next = S_G0;
      S_G0:    state_next = S_TX1;
      S_TX1:   state_next = S_E0A;
      S_E0A:   state_next = S_E0;
      S_E0:    state_next = S_E1;
      S_E1:    state_next = S_TA;
      S_TA:    state_next = S_TB;
      S_TB:    state_next = S_U;
      S_U:     state_next = S_S;
      S_S:     state_next = S_GU;
      S_GU:    state_next = S_XP0;
      S_XP0:   state_next = S_TU;
      S_TU:    state_next = S_XP1;
      S_XP1:   state_next = S_TP10;
      S_TP10:  state_next = S_P00A;
      S_P00A:  state_next = S_TP11;
      S_TP11:  state_next = S_P01;
      S_P01:   state_next = S_TP01;
      S_TP01:  state_next = S_P00B;
      S_P00B:  state_next = S_P00C;
      S_P00C:  state_next = S_TP11B;
      S_TP11B: state_next = S_P10;
      S_P10:   state_next = S_P11;
      S_P11:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // covariance c_ij is written back over p_ij once its last old read is done
  always_comb begin
    req       = '{OP_ADD, '0, '0};
    dst       = D_NONE;
    div_start = 1'b0;
    unique case (state)
      S_Z:     begin req = '{OP_ADD, vel, cfg.vel_offset};  dst = D_Z;     end
      S_D:     begin req = '{OP_ADD, p11, cfg.meas_noise};  dst = D_DSUM;  end
      S_DVS:   div_start = (dsum > q_t'(0));
      S_K0:    begin req = '{OP_MUL, p01, inv};             dst = D_K0;    end
      S_K1:    begin req = '{OP_MUL, p11, inv};             dst = D_K1;    end
      S_INNOV: begin req = '{OP_SUB, z, xp1};               dst = D_INNOV; end
      S_M1:    begin req = '{OP_MUL, k0, innov};            dst = D_M;     end
      S_X0:    begin req = '{OP_ADD, xp0, m};               dst = D_X0;    end
      S_M2:    begin req = '{OP_MUL, k1, innov};            dst = D_M;     end
      S_X1:    begin req = '{OP_ADD, xp1, m};               dst = D_X1;    end
      S_M3:    begin req = '{OP_MUL, k0, p10};              dst = D_M;     end
      S_C00:   begin req = '{OP_SUB, p00, m};               dst = D_P00;   end
      S_M4:    begin req = '{OP_MUL, k0, p11};              dst = D_M;     end
      S_C01:   begin req = '{OP_SUB, p01, m};               dst = D_P01;   end
      S_M5:    begin req = '{OP_MUL, k1, p10};              dst = D_M;     end
      S_C10:   begin req = '{OP_SUB, p10, m};               dst = D_P10;   end
      S_M6:    begin req = '{OP_MUL, k1, p11};              dst = D_M;     end
      S_C11:   begin req = '{OP_SUB, p11, m};               dst = D_P11;   end
      S_EMIT:  begin
        req = '{OP_SUB, pos, x0};
        dst = out_free ? D_OUT : D_NONE;
      end
      S_TT:    begin req = '{OP_MUL, cfg.step_time, cfg.step_time}; dst = D_M; end
      S_G0:    begin req = '{OP_SHR, m, '0};                dst = D_G0;    end
      S_TX1:   begin req = '{OP_MUL, cfg.step_time, x1};    dst = D_TX1;   end
      S_E0A:   begin req = '{OP_SUB, xp0, x0};              dst = D_E0;    end
      S_E0:    begin req = '{OP_SUB, e0, tx1};              dst = D_E0;    end
      S_E1:    begin req = '{OP_SUB, xp1, x1};              dst = D_E1;    end
      S_TA:    begin req = '{OP_MUL, g0, e0};               dst = D_TA;    end
      S_TB:    begin req = '{OP_MUL, cfg.step_time, e1};    dst = D_M;     end
      S_U:     begin req = '{OP_ADD, ta, m};                dst = D_U;     end
      S_S:     begin req = '{OP_ADD, x0, tx1};              dst = D_ACC;   end
      S_GU:    begin req = '{OP_MUL, g0, u};                dst = D_M;     end
      S_XP0:   begin req = '{OP_ADD, acc, m};               dst = D_XP0;   end
      S_TU:    begin req = '{OP_MUL, cfg.step_time, u};     dst = D_M;     end
      S_XP1:   begin req = '{OP_ADD, x1, m};                dst = D_XP1;   end
      S_TP10:  begin req = '{OP_MUL, cfg.step_time, p10};   dst = D_M;     end
      S_P00A:  begin req = '{OP_ADD, p00, m};               dst = D_P00;   end
      S_TP11:  begin req = '{OP_MUL, cfg.step_time, p11};   dst = D_M;     end
      S_P01:   begin req = '{OP_ADD, p01, m};               dst = D_P01;   end
      S_TP01:  begin req = '{OP_MUL, cfg.step_time, p01};   dst = D_M;     end
      S_P00B:  begin req = '{OP_ADD, p00, m};               dst = D_P00;   end
      S_P00C:  begin req = '{OP_ADD, p00, cfg.proc_noise_pos}; dst = D_P00; end
      S_TP11B: begin req = '{OP_MUL, cfg.step_time, p11};   dst = D_M;     end
      S_P10:   begin req = '{OP_ADD, p10, m};               dst = D_P10;   end
      S_P11:   begin req = '{OP_ADD, p11, cfg.proc_noise_vel}; dst = D_P11; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      started   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) started <= 1'b1;
      if (dst == D_OUT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pos <= sat_s32(in_data.meas_position);
      vel <= sat_s32(in_data.meas_velocity);
      if (!started) begin
        xp0 <= sat_s32(in_data.meas_position);
        xp1 <= sat_s32(in_data.meas_velocity);
        p00 <= cfg.init_var_pos;
        p01 <= '0;
        p10 <= '0;
        p11 <= cfg.init_var_vel;
      end
    end
    if (state == S_DVS && !(dsum > q_t'(0))) inv <= '0;
    else if (div_done) inv <= div_quo;
    case (dst)
      D_Z:     z     <= y;
      D_DSUM:  dsum  <= y;
      D_K0:    k0    <= y;
      D_K1:    k1    <= y;
      D_INNOV: innov <= y;
      D_M:     m     <= y;
      D_X0:    x0    <= y;
      D_X1:    x1    <= y;
      D_OUT:   out_data <= '{q_to_out(x0), q_to_out(x1), q_to_out(y)};
      D_G0:    g0    <= y;
      D_TX1:   tx1   <= y;
      D_E0:    e0    <= y;
      D_E1:    e1    <= y;
      D_TA:    ta    <= y;
      D_U:     u     <= y;
      D_ACC:   acc   <= y;
      D_XP0:   xp0   <= y;
      D_XP1:   xp1   <= y;
      D_P00:   p00   <= y;
      D_P01:   p01   <= y;
      D_P10:   p10   <= y;
      D_P11:   p11   <= y;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EMIT))
    else $error("result beat raised outside emit step");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("reciprocal finished while not waiting for it");

  a_first_tick_silent: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !started) |=> (state == S_IDLE && started && !$rose(out_valid)))
    else $error("first tick did not just load the prediction");

  a_div_start_idle_unit: assert property (@(posedge clk) disable iff (rst)
    div_start |=> state == S_DIV)
    else $error("reciprocal started without waiting for it");
`endif

endmodule

// ----- hw/rtl/kalman_pos_vel_velocity_meas.sv -----
// channel   dir  handshake              payload
// in        in   in_valid / in_ready    in_data   (meas_position, meas_velocity)
// out       out  out_valid / out_ready  out_data  (est_position, est_velocity, position_gap)
// cfg       in   cfg_we                 cfg_addr, cfg_wdata
//
// First tick after reset loads the prediction and gives no result.
// Later ticks: 44 sequencer steps plus the wait on the reciprocal; the
//   single shared multiplier/adder and the bit-serial divider set their length.
// A non-positive P11+R skips the reciprocal.
// Result sits in an output register; only the emit step stalls while it is held.
// Synchronous reset restores register defaults and the not-started state.
module kalman_pos_vel_velocity_meas (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  kpv_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output kpv_pkg::out_t  out_data,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_addr,
  input  logic [31:0]    cfg_wdata
);
  import kpv_pkg::*;

  logic [30:0] step_time;
  logic [30:0] meas_noise;
  logic [31:0] vel_offset;
  logic [30:0] proc_noise_pos;
  logic [30:0] proc_noise_vel;
  logic [30:0] init_var_pos;
  logic [30:0] init_var_vel;
  cfg_t        cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_time      <= 31'd1311;
      meas_noise     <= 31'd6554;
      vel_offset     <= 32'hFFFFF2D1;
      proc_noise_pos <= 31'd65536;
      proc_noise_vel <= 31'd65536;
      init_var_pos   <= 31'd6553600;
      init_var_vel   <= 31'd65536;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_STEP_TIME:      step_time      <= cfg_wdata[30:0];
        REG_MEAS_NOISE:     meas_noise     <= cfg_wdata[30:0];
        REG_VEL_OFFSET:     vel_offset     <= cfg_wdata;
        REG_PROC_NOISE_POS: proc_noise_pos <= cfg_wdata[30:0];
        REG_PROC_NOISE_VEL: proc_noise_vel <= cfg_wdata[30:0];
        REG_INIT_VAR_POS:   init_var_pos   <= cfg_wdata[30:0];
        REG_INIT_VAR_VEL:   init_var_vel   <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.step_time      = sat_u31(step_time);
    cfg.meas_noise     = sat_u31(meas_noise);
    cfg.vel_offset     = sat_s32(signed'(vel_offset));
    cfg.proc_noise_pos = sat_u31(proc_noise_pos);
    cfg.proc_noise_vel = sat_u31(proc_noise_vel);
    cfg.init_var_pos   = sat_u31(init_var_pos);
    cfg.init_var_vel   = sat_u31(init_var_vel);
  end

  kpv_core u_core (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule

// ----- tb/tb_kalman_pos_vel_velocity_meas.sv -----
`timescale 1ns / 100ps

module tb_kalman_pos_vel_velocity_meas;
  import kpv_pkg::*;

  typedef logic signed [63:0] s64_t;
  typedef logic signed [127:0] s128_t;

  localparam s64_t FMAX = 64'sh7FFFFFFF;
  localparam s64_t FMIN = -64'sh80000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  kalman_pos_vel_velocity_meas i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial forever #6 clk = ~clk;

  // filter state mirror
  s64_t reg_val[7];
  bit tracking;
  s64_t xp_pos, xp_vel, pc00, pc01, pc10, pc11;

  in_t samples_pending[$];
  out_t estimates_due[$];
  int unsigned mismatches = 0;
  int unsigned hold_off = 0;
  int unsigned hold_ask = 0;
  int unsigned hold_seen = 0;
  bit drain_ok = 1'b1;

  function automatic s64_t clip(s64_t v);
    if (v > FMAX) return FMAX;
    if (v < FMIN) return FMIN;
    return v;
  endfunction

  function automatic s64_t fadd(s64_t a, s64_t b);
    return clip(a + b);
  endfunction

  function automatic s64_t fsub(s64_t a, s64_t b);
    return clip(a - b);
  endfunction

  function automatic s64_t fmul(s64_t a, s64_t b);
    s128_t p;
    s128_t m;
    bit neg;
    p = s128_t'(a) * s128_t'(b);
    neg = p < 0;
    m = neg ? -p : p;
    m = (m + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (neg && m > s128_t'(-FMIN)) m = s128_t'(-FMIN);
    if (!neg && m > s128_t'(FMAX)) m = s128_t'(FMAX);
    return neg ? s64_t'(-m) : s64_t'(m);
  endfunction

  function automatic void reset_filter();
    reg_val[REG_STEP_TIME] = 1311;
    reg_val[REG_MEAS_NOISE] = 6554;
    reg_val[REG_VEL_OFFSET] = -3375;
    reg_val[REG_PROC_NOISE_POS] = 65536;
    reg_val[REG_PROC_NOISE_VEL] = 65536;
    reg_val[REG_INIT_VAR_POS] = 6553600;
    reg_val[REG_INIT_VAR_VEL] = 65536;
    tracking = 0;
    xp_pos = 0; xp_vel = 0; pc00 = 0; pc01 = 0; pc10 = 0; pc11 = 0;
  endfunction

  function automatic void track_sample(in_t s);
    s64_t pos, vel, t, z, d, k0, k1, inv, innov, x0, x1;
    s64_t c00, c01, c10, c11, g0, e0, e1, u, a00, a01, gap;
    logic [63:0] rec;
    out_t r;
    pos = s64_t'(s.meas_position);
    vel = s64_t'(s.meas_velocity);
    t = reg_val[REG_STEP_TIME];
    if (!tracking) begin
      xp_pos = pos; xp_vel = vel;
      pc00 = reg_val[REG_INIT_VAR_POS]; pc01 = 0; pc10 = 0;
      pc11 = reg_val[REG_INIT_VAR_VEL];
      tracking = 1;
      return;
    end
    z = fadd(vel, reg_val[REG_VEL_OFFSET]);
    d = fadd(pc11, reg_val[REG_MEAS_NOISE]);
    k0 = 0; k1 = 0;
    if (d > 0) begin
      rec = ((64'd1 << (2 * FRAC_BITS)) + 64'(d) / 2) / 64'(d);
      inv = rec > 64'(FMAX) ? FMAX : s64_t'(rec);
      k0 = fmul(pc01, inv);
      k1 = fmul(pc11, inv);
    end
    innov = fsub(z, xp_vel);
    x0 = fadd(xp_pos, fmul(k0, innov));
    x1 = fadd(xp_vel, fmul(k1, innov));
    c00 = fsub(pc00, fmul(k0, pc10));
    c01 = fsub(pc01, fmul(k0, pc11));
    c10 = fsub(pc10, fmul(k1, pc10));
    c11 = fsub(pc11, fmul(k1, pc11));
    gap = fsub(pos, x0);
    r.est_position = x0[31:0];
    r.est_velocity = x1[31:0];
    r.position_gap = gap[31:0];
    estimates_due.push_back(r);
    g0 = fmul(t, t) >>> 1;
    e0 = fsub(fsub(xp_pos, x0), fmul(t, x1));
    e1 = fsub(xp_vel, x1);
    u = fadd(fmul(g0, e0), fmul(t, e1));
    xp_pos = fadd(fadd(x0, fmul(t, x1)), fmul(g0, u));
    xp_vel = fadd(x1, fmul(t, u));
    a00 = fadd(c00, fmul(t, c10));
    a01 = fadd(c01, fmul(t, c11));
    pc00 = fadd(fadd(a00, fmul(t, a01)), reg_val[REG_PROC_NOISE_POS]);
    pc01 = a01;
    pc10 = fadd(c10, fmul(t, c11));
    pc11 = fadd(c11, reg_val[REG_PROC_NOISE_VEL]);
  endfunction

  // driver: bursts and gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        track_sample(in_data);
        void'(samples_pending.pop_front());
      end
      if (in_valid && !in_ready) begin
        // hold beat
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if ((samples_pending.size() > (in_valid && in_ready ? 0 : 0)) &&
                   samples_pending.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= samples_pending[0];
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 150);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  int unsigned stall_phase = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_seen != hold_ask) begin
      hold_seen <= hold_ask;
      hold_off <= 600;
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      case (stall_phase[9:8])
        2'd0: out_ready <= 1'b1;
        2'd1: out_ready <= ($urandom_range(0, 3) != 0);
        2'd2: out_ready <= (stall_phase[2:0] != 3'd5);
        default: out_ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (estimates_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected estimate beat %h", out_data);
      end else begin
        want = estimates_due.pop_front();
        if (want !== out_data) begin
          mismatches++;
          if (mismatches <= 10)
            $display("estimate mismatch: exp pos %0d vel %0d gap %0d, got %0d %0d %0d",
                     want.est_position, want.est_velocity, want.position_gap,
                     out_data.est_position, out_data.est_velocity, out_data.position_gap);
        end
      end
    end
  end

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom;
      default: return $signed($urandom_range(0, 2000000)) - 1000000;
    endcase
  endfunction

  task automatic wait_idle();
    while (samples_pending.size() > 0 || in_valid || estimates_due.size() > 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] v);
    logic [31:0] m;
    m = (idx == REG_VEL_OFFSET) ? v : {1'b0, v[30:0]};
    @(posedge clk);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_val[idx] = (idx == REG_VEL_OFFSET) ? s64_t'($signed(m)) : s64_t'(m);
  endtask

  task automatic add_track(int n, int unsigned spread);
    in_t s;
    int base_p, base_v;
    base_p = $signed($urandom_range(0, 400000)) - 200000;
    base_v = $signed($urandom_range(0, 40000)) - 20000;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        s.meas_position = rand_field();
        s.meas_velocity = rand_field();
      end else begin
        s.meas_position = base_p + $signed($urandom_range(0, spread)) - int'(spread / 2);
        s.meas_velocity = base_v + $signed($urandom_range(0, spread)) - int'(spread / 2);
        base_p += base_v / 50;
      end
      samples_pending.push_back(s);
    end
  endtask

  initial begin
    in_t s;
    reset_filter();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // directed: field extremes and bit toggles under reset values
    s.meas_position = 32'sh7FFFFFFF; s.meas_velocity = 32'sh80000000;
    samples_pending.push_back(s);
    s.meas_position = 32'sh80000000; s.meas_velocity = 32'sh7FFFFFFF;
    samples_pending.push_back(s);
    s.meas_position = 0; s.meas_velocity = 0;
    samples_pending.push_back(s);
    s.meas_position = 32'hFFFFFFFF; s.meas_velocity = 32'hFFFFFFFF;
    samples_pending.push_back(s);
    s.meas_position = 32'h55555555; s.meas_velocity = 32'hAAAAAAAA;
    samples_pending.push_back(s);
    s.meas_position = 32'hAAAAAAAA; s.meas_velocity = 32'h55555555;
    samples_pending.push_back(s);
    wait_idle();
    // non-positive divisor: zero noise and zero velocity variance
    write_reg(REG_MEAS_NOISE, 0);
    write_reg(REG_INIT_VAR_VEL, 0);
    write_reg(REG_PROC_NOISE_VEL, 0);
    add_track(6, 1000);
    wait_idle();
    // extremes of every register
    write_reg(REG_STEP_TIME, 32'h7FFFFFFF);
    write_reg(REG_MEAS_NOISE, 32'h7FFFFFFF);
    write_reg(REG_VEL_OFFSET, 32'h80000000);
    write_reg(REG_PROC_NOISE_POS, 32'h7FFFFFFF);
    write_reg(REG_PROC_NOISE_VEL, 32'h7FFFFFFF);
    write_reg(REG_INIT_VAR_POS, 32'h7FFFFFFF);
    write_reg(REG_INIT_VAR_VEL, 32'h7FFFFFFF);
    add_track(6, 100000);
    wait_idle();
    write_reg(REG_VEL_OFFSET, 32'h7FFFFFFF);
    write_reg(REG_STEP_TIME, 0);
    write_reg(REG_PROC_NOISE_POS, 0);
    write_reg(REG_INIT_VAR_POS, 0);
    add_track(5, 100000);
    wait_idle();
    // long receiver hold-off while sender keeps offering
    hold_ask++;
    add_track(40, 3000);
    wait_idle();
    // random phases with assorted settings
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_STEP_TIME, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 6000));
      write_reg(REG_MEAS_NOISE, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200000));
      write_reg(REG_VEL_OFFSET, $urandom_range(0, 3) == 0 ? $urandom
                : $signed($urandom_range(0, 20000)) - 10000);
      write_reg(REG_PROC_NOISE_POS, $urandom_range(0, 3) == 0 ? $urandom
                : $urandom_range(0, 200000));
      write_reg(REG_PROC_NOISE_VEL, $urandom_range(0, 3) == 0 ? $urandom
                : $urandom_range(0, 200000));
      write_reg(REG_INIT_VAR_POS, $urandom_range(0, 3) == 0 ? $urandom
                : $urandom_range(0, 8000000));
      write_reg(REG_INIT_VAR_VEL, $urandom_range(0, 3) == 0 ? $urandom
                : $urandom_range(0, 200000));
      add_track(200, $urandom_range(0, 1) ? 500 : 50000);
      wait_idle();
    end
    if (mismatches == 0 && estimates_due.size() == 0 && drain_ok) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/kpv_pkg.sv
hw/rtl/kpv_alu.sv
hw/rtl/kpv_div.sv
hw/rtl/kpv_core.sv
hw/rtl/kalman_pos_vel_velocity_meas.sv
tb/tb_kalman_pos_vel_velocity_meas.sv
